### rtl/assert_macros.svh
// Assertion macros used by the position hash top level.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, clocked, reset-gated.
`define LPPH_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define LPPH_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/lpph_pkg.sv
// Types and constants for the linear-probe position hash.
// Used by lpph_home and linear_probe_position_hash; no dependencies.
package lpph_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned SWEEP_W  = 8;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned STATUS_W = 3;

    // s_tdata layout, lowest bit first
    localparam int unsigned KX_LSB  = 0;
    localparam int unsigned KZ_LSB  = KX_LSB + KEY_W;
    localparam int unsigned HD_LSB  = KZ_LSB + KEY_W;
    localparam int unsigned SB_LSB  = HD_LSB + HANDLE_W;
    localparam int unsigned S_DATA_W = SB_LSB + SWEEP_W;   // 88, whole bytes
    localparam int unsigned M_DATA_W = HANDLE_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_SWEEP  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_STORED   = 3'd0,
        STAT_HIT      = 3'd1,
        STAT_MISS     = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_RELEASED = 3'd4,
        STAT_NONE     = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_RESP
    } state_t;

    // one bucket as stored in the table RAM
    typedef struct packed {
        logic                occupied;
        logic                active;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key_z;
        logic [KEY_W-1:0]    key_x;
    } entry_t;

endpackage

### rtl/lpph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpph_ram #(
    parameter int unsigned WIDTH = 82,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lpph_home.sv
// Home bucket unit: h = x + 31*z mod 2^32, then h mod TABLE_SIZE.
// Power-of-two sizes take the low bits; other sizes use a reciprocal
// multiply, a back-multiply and one compare-subtract. Uses lpph_pkg.
module lpph_home #(
    parameter int unsigned TABLE_SIZE = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lpph_pkg::KEY_W-1:0]     key_x,
    input  logic [lpph_pkg::KEY_W-1:0]     key_z,
    output logic                           done,
    output logic [$clog2(TABLE_SIZE)-1:0]  bucket
);

    localparam int unsigned AW = $clog2(TABLE_SIZE);
    localparam int unsigned KW = lpph_pkg::KEY_W;
    localparam int unsigned PW = 2 * KW;
    localparam bit IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);
    // floor(2^32 / TABLE_SIZE): the quotient estimate is short by at most one
    localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / TABLE_SIZE);
    localparam logic [KW-1:0] TSIZE = KW'(TABLE_SIZE);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [KW-1:0]              h_reg, h_next;
    logic [PW-1:0]              prod_reg, prod_next;
    logic [KW-1:0]              rem_reg, rem_next;
    logic [1:0]                 step_reg, step_next;
    logic [AW-1:0]              bucket_reg, bucket_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        h_reg      <= h_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        step_reg   <= step_next;
        bucket_reg <= bucket_next;
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        h_next      = h_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        bucket_next = bucket_reg;
        if (start) begin
            // 31*z as (z << 5) - z
            h_next    = key_x + {key_z[KW-6:0], 5'b0} - key_z;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (IS_POW2) begin
                bucket_next = h_reg[AW-1:0];
                done_next   = 1'b1;
                busy_next   = 1'b0;
            end else begin
                case (step_reg)
                    2'd0: begin
                        prod_next = PW'(h_reg) * PW'(RECIP);
                        step_next = 2'd1;
                    end
                    2'd1: begin
                        rem_next  = h_reg - KW'(prod_reg[PW-1:KW] * TSIZE);
                        step_next = 2'd2;
                    end
                    default: begin
                        // remainder estimate is below 2*TABLE_SIZE
                        if (rem_reg >= TSIZE) begin
                            bucket_next = AW'(rem_reg - TSIZE);
                        end else begin
                            bucket_next = AW'(rem_reg);
                        end
                        done_next = 1'b1;
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

### rtl/linear_probe_position_hash.sv
// Linear-probe position hash: top level, sequencer and table RAM.
// Uses lpph_pkg, lpph_home, lpph_ram and assert_macros.svh.
//
//   channel  dir  payload                                       handshake
//   s_       in   tuser: kind; tdata: x, z, handle, sweep bucket tvalid/tready
//   m_       out  tuser: status; tdata: result handle            tvalid/tready
//
// Insert/lookup probe one bucket per cycle on the RAM read port; non
// power-of-two sizes add a multiply-based reduction before the first
// probe. Sweep reads one bucket. Kind 3 is dropped on accept.
// After reset a clearing pass writes every bucket, with s_tready low.
// A stalled m_ beat is held in the output register; the next item may
// be accepted but does not finish until it leaves.
`include "assert_macros.svh"

module linear_probe_position_hash #(
    parameter int unsigned TABLE_SIZE = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpph_pkg::S_DATA_W-1:0] s_tdata,  // key_x, key_z, entry_handle, sweep_bucket
    input  logic [lpph_pkg::KIND_W-1:0]   s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpph_pkg::M_DATA_W-1:0] m_tdata,  // result_handle
    output logic [lpph_pkg::STATUS_W-1:0] m_tuser   // status
);

    localparam int unsigned AW = $clog2(TABLE_SIZE);
    localparam int unsigned EW = $bits(lpph_pkg::entry_t);
    localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

    lpph_pkg::state_t  state_reg, state_next;
    lpph_pkg::kind_t   kind_reg, kind_next;
    logic [lpph_pkg::KEY_W-1:0]    kx_reg, kx_next;
    logic [lpph_pkg::KEY_W-1:0]    kz_reg, kz_next;
    logic [lpph_pkg::HANDLE_W-1:0] hd_reg, hd_next;
    logic [AW-1:0]                 probe_reg, probe_next;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    lpph_pkg::status_t             res_status_reg, res_status_next;
    logic [lpph_pkg::HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    lpph_pkg::status_t             out_status_reg, out_status_next;
    logic [lpph_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;

    logic                          accept;
    logic [lpph_pkg::KEY_W-1:0]    in_kx, in_kz;
    logic [lpph_pkg::HANDLE_W-1:0] in_hd;
    logic [lpph_pkg::SWEEP_W-1:0]  in_sb;
    logic                          sb_in_range;
    logic                          home_start, home_done;
    logic [AW-1:0]                 home_bucket;
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    lpph_pkg::entry_t              ram_wentry, rd_entry;
    logic [EW-1:0]                 ram_rdata;
    logic                          key_hit;
    logic [AW-1:0]                 probe_inc;

    assign accept = s_tvalid && s_tready;
    assign in_kx  = s_tdata[lpph_pkg::KX_LSB +: lpph_pkg::KEY_W];
    assign in_kz  = s_tdata[lpph_pkg::KZ_LSB +: lpph_pkg::KEY_W];
    assign in_hd  = s_tdata[lpph_pkg::HD_LSB +: lpph_pkg::HANDLE_W];
    assign in_sb  = s_tdata[lpph_pkg::SB_LSB +: lpph_pkg::SWEEP_W];
    assign sb_in_range = (32'(in_sb) < 32'(TABLE_SIZE));

    assign rd_entry  = lpph_pkg::entry_t'(ram_rdata);
    assign key_hit   = rd_entry.occupied && (rd_entry.key_x == kx_reg)
                       && (rd_entry.key_z == kz_reg);
    assign probe_inc = (probe_reg == LAST) ? '0 : probe_reg + AW'(1);

    lpph_home #(
        .TABLE_SIZE(TABLE_SIZE)
    ) u_home (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (home_start),
        .key_x  (in_kx),
        .key_z  (in_kz),
        .done   (home_done),
        .bucket (home_bucket)
    );

    lpph_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_SIZE)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lpph_pkg::ST_CLEAR;
            m_tvalid_reg <= 1'b0;
            probe_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            probe_reg    <= probe_next;
        end
        kind_reg       <= kind_next;
        kx_reg         <= kx_next;
        kz_reg         <= kz_next;
        hd_reg         <= hd_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        out_status_reg <= out_status_next;
        out_handle_reg <= out_handle_next;
    end

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        kx_next         = kx_reg;
        kz_next         = kz_reg;
        hd_next         = hd_reg;
        probe_next      = probe_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        out_status_next = out_status_reg;
        out_handle_next = out_handle_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        home_start      = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = probe_reg;
        ram_wentry      = '0;
        ram_re          = 1'b0;
        ram_raddr       = probe_reg;

        case (state_reg)
            lpph_pkg::ST_CLEAR: begin
                // probe_reg doubles as the clear address
                ram_we     = 1'b1;
                probe_next = probe_inc;
                if (probe_reg == LAST) begin
                    state_next = lpph_pkg::ST_IDLE;
                end
            end
            lpph_pkg::ST_IDLE: begin
                if (accept) begin
                    kind_next       = lpph_pkg::kind_t'(s_tuser);
                    kx_next         = in_kx;
                    kz_next         = in_kz;
                    hd_next         = in_hd;
                    res_handle_next = '0;
                    case (lpph_pkg::kind_t'(s_tuser))
                        lpph_pkg::KIND_INSERT, lpph_pkg::KIND_LOOKUP: begin
                            home_start = 1'b1;
                            state_next = lpph_pkg::ST_HASH;
                        end
                        lpph_pkg::KIND_SWEEP: begin
                            if (sb_in_range) begin
                                probe_next = AW'(in_sb);
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(in_sb);
                                state_next = lpph_pkg::ST_CHECK;
                            end else begin
                                res_status_next = lpph_pkg::STAT_NONE;
                                state_next      = lpph_pkg::ST_RESP;
                            end
                        end
                        default: begin
                            // unused kind: dropped
                            state_next = lpph_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lpph_pkg::ST_HASH: begin
                if (home_done) begin
                    probe_next = home_bucket;
                    cnt_next   = '0;
                    ram_re     = 1'b1;
                    ram_raddr  = home_bucket;
                    state_next = lpph_pkg::ST_CHECK;
                end
            end
            lpph_pkg::ST_CHECK: begin
                // rd_entry belongs to probe_reg; a continued probe reads the next bucket
                case (kind_reg)
                    lpph_pkg::KIND_INSERT: begin
                        if (!rd_entry.occupied) begin
                            ram_we                = 1'b1;
                            ram_wentry.occupied   = 1'b1;
                            ram_wentry.handle     = hd_reg;
                            ram_wentry.key_x      = kx_reg;
                            ram_wentry.key_z      = kz_reg;
                            res_status_next       = lpph_pkg::STAT_STORED;
                            state_next            = lpph_pkg::ST_RESP;
                        end else if (cnt_reg == LAST) begin
                            res_status_next = lpph_pkg::STAT_FULL;
                            state_next      = lpph_pkg::ST_RESP;
                        end else begin
                            probe_next = probe_inc;
                            cnt_next   = cnt_reg + AW'(1);
                            ram_re     = 1'b1;
                            ram_raddr  = probe_inc;
                        end
                    end
                    lpph_pkg::KIND_LOOKUP: begin
                        if (key_hit) begin
                            ram_we            = 1'b1;
                            ram_wentry        = rd_entry;
                            ram_wentry.active = 1'b1;
                            res_status_next   = lpph_pkg::STAT_HIT;
                            res_handle_next   = rd_entry.handle;
                            state_next        = lpph_pkg::ST_RESP;
                        end else if ((cnt_reg == '0 && !rd_entry.occupied)
                                     || cnt_reg == LAST) begin
                            // empty home bucket, or every bucket seen
                            res_status_next = lpph_pkg::STAT_MISS;
                            state_next      = lpph_pkg::ST_RESP;
                        end else begin
                            probe_next = probe_inc;
                            cnt_next   = cnt_reg + AW'(1);
                            ram_re     = 1'b1;
                            ram_raddr  = probe_inc;
                        end
                    end
                    default: begin
                        // sweep: empty the bucket, release if idle entry
                        ram_we = 1'b1;
                        if (rd_entry.occupied && !rd_entry.active) begin
                            res_status_next = lpph_pkg::STAT_RELEASED;
                            res_handle_next = rd_entry.handle;
                        end else begin
                            res_status_next = lpph_pkg::STAT_NONE;
                        end
                        state_next = lpph_pkg::ST_RESP;
                    end
                endcase
            end
            lpph_pkg::ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_status_next = res_status_reg;
                    out_handle_next = res_handle_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = lpph_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpph_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == lpph_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_handle_reg;
    assign m_tuser  = out_status_reg;

    `LPPH_NEVER(a_no_accept_clear, aclk, aresetn, state_reg == lpph_pkg::ST_CLEAR && s_tready, "accept during clearing pass")
    `LPPH_ASSERT(a_write_ends_probe, aclk, aresetn, (state_reg == lpph_pkg::ST_CHECK && ram_we) |=> state_reg == lpph_pkg::ST_RESP, "table write did not end the probe")
    `LPPH_ASSERT(a_probe_bounded, aclk, aresetn, (state_reg == lpph_pkg::ST_CHECK && cnt_reg == LAST && kind_reg != lpph_pkg::KIND_SWEEP) |=> state_reg == lpph_pkg::ST_RESP, "probe ran past the table")
    `LPPH_ASSERT(a_zero_handle, aclk, aresetn, (m_tvalid && m_tuser != lpph_pkg::STAT_HIT && m_tuser != lpph_pkg::STAT_RELEASED) |-> m_tdata == '0, "nonzero handle on a handle-less status")

endmodule

### tb/sv/lpph_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the linear-probe position hash: watches both stream channels,
// keeps its own copy of the bucket table and checks every result beat.
// Depends on lpph_pkg for widths, the tdata layout and the kind/status codes.
module lpph_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [lpph_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [lpph_pkg::KIND_W-1:0]   s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [lpph_pkg::M_DATA_W-1:0] m_tdata,
    input  logic [lpph_pkg::STATUS_W-1:0] m_tuser,
    output int                            mismatch_count,
    output int                            replies_due
);
    import lpph_pkg::*;

    localparam int unsigned BUCKETS     = 256;
    localparam int          REPLY_DEPTH = 64;

    typedef struct packed {
        status_t             status;
        logic [HANDLE_W-1:0] handle;
    } reply_t;

    logic [KEY_W-1:0]    bucket_x      [BUCKETS];
    logic [KEY_W-1:0]    bucket_z      [BUCKETS];
    logic [HANDLE_W-1:0] bucket_handle [BUCKETS];
    logic                bucket_used   [BUCKETS];
    logic                bucket_active [BUCKETS];

    // expected replies in order, as a ring
    reply_t reply_fifo [REPLY_DEPTH];
    int     wr_ptr;
    int     rd_ptr;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    endtask

    task automatic enqueue_reply(input reply_t r);
        if (wr_ptr - rd_ptr >= REPLY_DEPTH) begin
            report_mismatch("reply backlog", 32'(wr_ptr - rd_ptr), 32'(REPLY_DEPTH));
        end else begin
            reply_fifo[wr_ptr % REPLY_DEPTH] = r;
            wr_ptr++;
        end
    endtask

    // Applies one accepted beat to the table copy and queues its reply.
    task automatic apply_table_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] kx,
                                  input logic [KEY_W-1:0] kz, input logic [HANDLE_W-1:0] hd,
                                  input logic [SWEEP_W-1:0] sb);
        logic [KEY_W-1:0] h;
        int unsigned      b;
        int unsigned      n;
        reply_t           r;
        h = kx + 32'd31 * kz;
        b = h % BUCKETS;
        r.handle = '0;
        case (kind)
            KIND_INSERT: begin
                r.status = STAT_FULL;
                for (n = 0; n < BUCKETS; n++) begin
                    if (!bucket_used[b]) begin
                        bucket_x[b]      = kx;
                        bucket_z[b]      = kz;
                        bucket_handle[b] = hd;
                        bucket_used[b]   = 1'b1;
                        bucket_active[b] = 1'b0;
                        r.status = STAT_STORED;
                        break;
                    end
                    b = (b + 1) % BUCKETS;
                end
                enqueue_reply(r);
            end
            KIND_LOOKUP: begin
                r.status = STAT_MISS;
                // empty home bucket ends the search at once
                if (bucket_used[b]) begin
                    for (n = 0; n < BUCKETS; n++) begin
                        if (bucket_used[b] && bucket_x[b] == kx && bucket_z[b] == kz) begin
                            bucket_active[b] = 1'b1;
                            r.handle = bucket_handle[b];
                            r.status = STAT_HIT;
                            break;
                        end
                        b = (b + 1) % BUCKETS;
                    end
                end
                enqueue_reply(r);
            end
            KIND_SWEEP: begin
                r.status = STAT_NONE;
                if (sb < BUCKETS) begin
                    if (bucket_used[sb] && !bucket_active[sb]) begin
                        r.handle = bucket_handle[sb];
                        r.status = STAT_RELEASED;
                    end
                    bucket_used[sb]   = 1'b0;
                    bucket_active[sb] = 1'b0;
                end
                enqueue_reply(r);
            end
            default: ;  // unused kind: dropped, no reply
        endcase
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < BUCKETS; i++) begin
                bucket_used[i]   = 1'b0;
                bucket_active[i] = 1'b0;
            end
            wr_ptr = 0;
            rd_ptr = 0;
            mismatch_count = 0;
        end else begin
            // result beats always belong to earlier input beats, so check first
            if (m_tvalid && m_tready) begin
                if (wr_ptr == rd_ptr) begin
                    report_mismatch("unexpected result beat", 32'({m_tuser, m_tdata}), '0);
                end else begin
                    want = reply_fifo[rd_ptr % REPLY_DEPTH];
                    rd_ptr++;
                    if (m_tuser !== want.status)
                        report_mismatch("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata !== want.handle)
                        report_mismatch("result_handle", 32'(m_tdata), 32'(want.handle));
                end
            end
            if (s_tvalid && s_tready)
                apply_table_op(s_tuser, s_tdata[KX_LSB +: KEY_W], s_tdata[KZ_LSB +: KEY_W],
                               s_tdata[HD_LSB +: HANDLE_W], s_tdata[SB_LSB +: SWEEP_W]);
        end
        replies_due = wr_ptr - rd_ptr;
    end

endmodule

### tb/sv/linear_probe_position_hash_test.sv
`timescale 1ns / 1ps
// Top of the position hash testbench: clock, reset, directed and random beats,
// receiver backpressure and the verdict. Needs lpph_pkg, lpph_checker and the RTL.
module linear_probe_position_hash_test;
    import lpph_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                CYCLE_LIMIT  = 2_000_000;
    localparam int                DRAIN_CYCLES = 300;
    localparam int                HOLD_CYCLES  = 400;
    localparam int                POOL_DEPTH   = 64;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    int mismatch_count;
    int replies_due;
    int cycle_count;
    int burst_left;
    bit hold_req;

    logic [KEY_W-1:0] pool_x [POOL_DEPTH];
    logic [KEY_W-1:0] pool_z [POOL_DEPTH];
    int               pool_n;

    linear_probe_position_hash #(.TABLE_SIZE(256)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lpph_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .replies_due    (replies_due)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic logic [SWEEP_W-1:0] home_bucket(input logic [KEY_W-1:0] kx,
                                                       input logic [KEY_W-1:0] kz);
        logic [KEY_W-1:0] h;
        h = kx + 32'd31 * kz;
        return h[SWEEP_W-1:0];
    endfunction

    // Called right after a falling edge; returns right after the falling edge
    // that follows acceptance.
    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] kx,
                             input logic [KEY_W-1:0] kz, input logic [HANDLE_W-1:0] hd,
                             input logic [SWEEP_W-1:0] sb);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tuser  <= kind;
        s_tdata  <= {sb, hd, kz, kx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic fresh_key(output logic [KEY_W-1:0] kx, output logic [KEY_W-1:0] kz);
        if ($urandom_range(0, 4) < 3) begin
            kx = $urandom;
            kz = $urandom;
        end else begin
            // small coordinates around the origin, both signs
            kx = $urandom_range(0, 31) - 16;
            kz = $urandom_range(0, 31) - 16;
        end
    endtask

    task automatic remember_key(input logic [KEY_W-1:0] kx, input logic [KEY_W-1:0] kz);
        int slot;
        slot = (pool_n < POOL_DEPTH) ? pool_n : $urandom_range(0, POOL_DEPTH - 1);
        pool_x[slot] = kx;
        pool_z[slot] = kz;
        if (pool_n < POOL_DEPTH) pool_n++;
    endtask

    // One random beat; weights in percent, the remainder goes to the unused kind.
    task automatic random_op(input int w_insert, input int w_lookup, input int w_sweep);
        int               r;
        int               p;
        logic [KEY_W-1:0] kx;
        logic [KEY_W-1:0] kz;
        logic [SWEEP_W-1:0] sb;
        r  = $urandom_range(0, 99);
        p  = (pool_n > 0) ? $urandom_range(0, pool_n - 1) : 0;
        kx = $urandom;
        kz = $urandom;
        sb = SWEEP_W'($urandom);
        if (r < w_insert) begin
            if (pool_n > 0 && $urandom_range(0, 3) == 0) begin
                kx = pool_x[p];  // duplicate key
                kz = pool_z[p];
            end else begin
                fresh_key(kx, kz);
                remember_key(kx, kz);
            end
            send_beat(KIND_INSERT, kx, kz, HANDLE_W'($urandom), sb);
        end else if (r < w_insert + w_lookup) begin
            if (pool_n > 0 && $urandom_range(0, 3) != 0) begin
                kx = pool_x[p];
                kz = pool_z[p];
            end else begin
                fresh_key(kx, kz);
            end
            send_beat(KIND_LOOKUP, kx, kz, HANDLE_W'($urandom), sb);
        end else if (r < w_insert + w_lookup + w_sweep) begin
            if (pool_n > 0 && $urandom_range(0, 1) == 0)
                sb = home_bucket(pool_x[p], pool_z[p]) + SWEEP_W'($urandom_range(0, 2));
            send_beat(KIND_SWEEP, kx, kz, HANDLE_W'($urandom), sb);
        end else begin
            send_beat(KIND_UNUSED, kx, kz, HANDLE_W'($urandom), sb);
        end
    endtask

    // receiver backpressure, with one long hold-off on request
    initial begin : receiver
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 160);
                end
                mode_left--;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 1) == 1);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        burst_left = 0;
        hold_req   = 1'b0;
        pool_n     = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, duplicates, wrap-around, early miss, sweeps
        send_beat(KIND_LOOKUP, 32'h0, 32'h0, 16'hFFFF, 8'hFF);            // empty table
        send_beat(KIND_INSERT, 32'h0, 32'h0, 16'h0000, 8'h00);
        send_beat(KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 8'hFF);
        send_beat(KIND_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8001, 8'hAA);
        send_beat(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1234, 8'h55);
        send_beat(KIND_INSERT, 32'h0, 32'h0, 16'hBEEF, 8'h00);            // duplicate key
        send_beat(KIND_LOOKUP, 32'h0, 32'h0, 16'h0, 8'h0);                // first in probe order
        send_beat(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 8'h0);
        send_beat(KIND_LOOKUP, 32'd31, 32'hFFFF_FFFF, 16'h0, 8'h0);       // shared home, absent
        send_beat(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0, home_bucket(32'h0, 32'h0));   // active
        send_beat(KIND_LOOKUP, 32'h0, 32'h0, 16'h0, 8'h0);                // home now empty
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0, home_bucket(32'h0, 32'h0) + 8'd1);
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0,
                  home_bucket(32'h7FFF_FFFF, 32'h8000_0000));
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0,
                  home_bucket(32'h8000_0000, 32'h7FFF_FFFF));
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0, home_bucket(32'h0, 32'h0));   // empty
        send_beat(KIND_INSERT, 32'd255, 32'h0, 16'h00FF, 8'h00);          // last bucket
        send_beat(KIND_INSERT, 32'd255, 32'h0, 16'h0100, 8'h00);          // wraps to bucket 0
        send_beat(KIND_LOOKUP, 32'd255, 32'h0, 16'h0, 8'h0);
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0, 8'hFF);
        send_beat(KIND_LOOKUP, 32'd255, 32'h0, 16'h0, 8'h0);
        send_beat(KIND_SWEEP, 32'h0, 32'h0, 16'h0, 8'h00);

        // mixed traffic; the receiver holds off for a while at the start
        hold_req = 1'b1;
        repeat (500) random_op(35, 40, 20);
        // fill the table and keep inserting past full
        repeat (280) random_op(100, 0, 0);
        repeat (60) random_op(0, 100, 0);
        // empty every bucket
        for (int b = 0; b < 256; b++)
            send_beat(KIND_SWEEP, $urandom, $urandom, HANDLE_W'($urandom), b[SWEEP_W-1:0]);
        repeat (100) random_op(30, 35, 30);

        s_tvalid <= 1'b0;
        while (replies_due != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### linear_probe_position_hash.f
+incdir+rtl
rtl/lpph_pkg.sv
rtl/lpph_ram.sv
rtl/lpph_home.sv
rtl/linear_probe_position_hash.sv
tb/sv/lpph_checker.sv
tb/sv/linear_probe_position_hash_test.sv
